FILE: design/hhmm_pkg.sv
// shared types, codes and helper functions of the hours-and-minutes clock
`timescale 1ns / 1ps

package hhmm_pkg;

   // event codes carried in the cmd field
   localparam logic [2:0] CMD_SECOND_TICK = 3'd0;
   localparam logic [2:0] CMD_SERIAL_BYTE = 3'd1;
   localparam logic [2:0] CMD_BUTTON      = 3'd2;
   localparam logic [2:0] CMD_HALF_TICK   = 3'd3;
   localparam logic [2:0] CMD_SCAN_STEP   = 3'd4;

   // register indexes on the csr port
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOUR_LIMIT   = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MINUTE_LIMIT = 1'd1;

   localparam logic [4:0] HOUR_LIMIT_RESET   = 5'd23;
   localparam logic [5:0] MINUTE_LIMIT_RESET = 6'd59;

   // serial byte ranges
   localparam logic [7:0] BYTE_HOUR_END    = 8'd24;
   localparam logic [7:0] BYTE_MINUTE_BASE = 8'd100;
   localparam logic [7:0] BYTE_MINUTE_LAST = 8'd159;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] byte_value;
      logic       set_pressed;
      logic       hour_pressed;
      logic       minute_pressed;
   } req_type;

   typedef struct packed {
      logic [4:0]  hours_now;
      logic [5:0]  minutes_now;
      logic [5:0]  seconds_now;
      logic [11:0] shown_value;
      logic        colon_on;
      logic [3:0]  digit_enable;
      logic [6:0]  segments;
   } rsp_type;

   typedef struct packed {
      logic [4:0] hour_limit;
      logic [5:0] minute_limit;
   } limits_type;

   typedef struct packed {
      logic       active;
      logic [1:0] position;
      logic [4:0] hour;
      logic [5:0] minute;
   } scan_type;

   // advance by one, wrap to zero past the limit; msb flags the wrap
   function automatic logic [6:0] bump6(input logic [5:0] v, input logic [5:0] lim);
      logic [6:0] n;
      n = {1'b0, v} + 7'd1;
      if (n > {1'b0, lim}) begin
         bump6 = {1'b1, 6'd0};
      end else begin
         bump6 = {1'b0, n[5:0]};
      end
   endfunction

   function automatic logic [5:0] bump5(input logic [4:0] v, input logic [4:0] lim);
      logic [5:0] n;
      n = {1'b0, v} + 6'd1;
      if (n > {1'b0, lim}) begin
         bump5 = {1'b1, 5'd0};
      end else begin
         bump5 = {1'b0, n[4:0]};
      end
   endfunction

   // tens of a value below 64, by reciprocal multiply
   function automatic logic [2:0] tens6(input logic [5:0] v);
      logic [13:0] p;
      p = 14'(v) * 14'd205;
      tens6 = p[13:11];
   endfunction

   function automatic logic [6:0] seg_code(input logic [3:0] d);
      case (d)
         4'd0: seg_code = 7'h3F;
         4'd1: seg_code = 7'h06;
         4'd2: seg_code = 7'h5B;
         4'd3: seg_code = 7'h4F;
         4'd4: seg_code = 7'h66;
         4'd5: seg_code = 7'h6D;
         4'd6: seg_code = 7'h7D;
         4'd7: seg_code = 7'h07;
         4'd8: seg_code = 7'h7F;
         4'd9: seg_code = 7'h6F;
         default: seg_code = 7'h00;
      endcase
   endfunction

endpackage

FILE: design/hhmm_seg_decode.sv
// digit pick and seven-segment decode for the scanned position
`timescale 1ns / 1ps

module hhmm_seg_decode (
   input  hhmm_pkg::scan_type scan,
   output logic [3:0]         digit_enable,
   output logic [6:0]         segments
);

   logic [2:0] min_tens;
   logic [3:0] min_ones;
   logic [2:0] hour_tens;
   logic [3:0] hour_ones;
   logic [3:0] digit;
   logic [5:0] min_sub;
   logic [5:0] hour_sub;

   always_comb begin
      min_tens  = hhmm_pkg::tens6(scan.minute);
      min_sub   = scan.minute - 6'(min_tens) * 6'd10;
      min_ones  = min_sub[3:0];
      hour_tens = hhmm_pkg::tens6({1'b0, scan.hour});
      hour_sub  = {1'b0, scan.hour} - 6'(hour_tens) * 6'd10;
      hour_ones = hour_sub[3:0];
      case (scan.position)
         2'd0: digit = min_ones;
         2'd1: digit = {1'b0, min_tens};
         2'd2: digit = hour_ones;
         2'd3: digit = {1'b0, hour_tens};
         default: digit = 4'd0;
      endcase
      if (scan.active) begin
         digit_enable = 4'b0001 << scan.position;
         segments     = hhmm_pkg::seg_code(digit);
      end else begin
         digit_enable = 4'd0;
         segments     = 7'd0;
      end
   end

endmodule

FILE: design/hhmm_clock_core.sv
// time keeping state and its update for one event item
`timescale 1ns / 1ps

module hhmm_clock_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  hhmm_pkg::req_type    item,
   input  hhmm_pkg::limits_type limits,
   output hhmm_pkg::rsp_type    result
);

   logic [5:0] second_ff, second_in;
   logic [5:0] minute_ff, minute_in;
   logic [4:0] hour_ff, hour_in;
   logic [4:0] rx_hour_ff, rx_hour_in;
   logic [5:0] rx_minute_ff, rx_minute_in;
   logic       blink_ff, blink_in;
   logic       set_mode_ff, set_mode_in;
   logic [1:0] scan_pos_ff, scan_pos_in;

   logic [6:0] sec_bump;
   logic [6:0] min_bump;
   logic [5:0] hour_bump;
   logic [7:0] byte_off;
   hhmm_pkg::scan_type scan;
   logic [3:0] digit_enable;
   logic [6:0] segments;

   always_comb begin
      second_in    = second_ff;
      minute_in    = minute_ff;
      hour_in      = hour_ff;
      rx_hour_in   = rx_hour_ff;
      rx_minute_in = rx_minute_ff;
      blink_in     = blink_ff;
      set_mode_in  = set_mode_ff;
      scan_pos_in  = scan_pos_ff;
      sec_bump     = hhmm_pkg::bump6(second_ff, limits.minute_limit);
      min_bump     = hhmm_pkg::bump6(minute_ff, limits.minute_limit);
      hour_bump    = hhmm_pkg::bump5(hour_ff, limits.hour_limit);
      byte_off     = item.byte_value - hhmm_pkg::BYTE_MINUTE_BASE;
      case (item.cmd)
         hhmm_pkg::CMD_SECOND_TICK: begin
            second_in = sec_bump[5:0];
            if (sec_bump[6]) begin
               minute_in = min_bump[5:0];
               if (min_bump[6]) begin
                  hour_in = hour_bump[4:0];
               end
            end
         end
         hhmm_pkg::CMD_SERIAL_BYTE: begin
            if (item.byte_value < hhmm_pkg::BYTE_HOUR_END) begin
               rx_hour_in = item.byte_value[4:0];
            end else if (item.byte_value >= hhmm_pkg::BYTE_MINUTE_BASE &&
                         item.byte_value <= hhmm_pkg::BYTE_MINUTE_LAST) begin
               rx_minute_in = byte_off[5:0];
            end
            hour_in   = rx_hour_in;
            minute_in = rx_minute_in;
         end
         hhmm_pkg::CMD_BUTTON: begin
            set_mode_in = item.set_pressed;
            if (item.set_pressed) begin
               if (item.hour_pressed) begin
                  hour_in = hour_bump[4:0];
               end
               if (item.minute_pressed) begin
                  minute_in = min_bump[5:0];
               end
            end
         end
         hhmm_pkg::CMD_HALF_TICK: begin
            blink_in = ~blink_ff;
         end
         hhmm_pkg::CMD_SCAN_STEP: begin
            scan_pos_in = scan_pos_ff + 2'd1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      scan.active   = (item.cmd == hhmm_pkg::CMD_SCAN_STEP);
      scan.position = scan_pos_ff;
      scan.hour     = hour_in;
      scan.minute   = minute_in;
   end

   hhmm_seg_decode u_seg_decode (
      .scan         (scan),
      .digit_enable (digit_enable),
      .segments     (segments)
   );

   always_comb begin
      result.hours_now    = hour_in;
      result.minutes_now  = minute_in;
      result.seconds_now  = second_in;
      result.shown_value  = 12'(hour_in) * 12'd100 + 12'(minute_in);
      result.colon_on     = set_mode_in | blink_in;
      result.digit_enable = digit_enable;
      result.segments     = segments;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff    <= 6'd0;
         minute_ff    <= 6'd0;
         hour_ff      <= 5'd0;
         rx_hour_ff   <= 5'd0;
         rx_minute_ff <= 6'd0;
         blink_ff     <= 1'b0;
         set_mode_ff  <= 1'b0;
         scan_pos_ff  <= 2'd0;
      end else if (fire) begin
         second_ff    <= second_in;
         minute_ff    <= minute_in;
         hour_ff      <= hour_in;
         rx_hour_ff   <= rx_hour_in;
         rx_minute_ff <= rx_minute_in;
         blink_ff     <= blink_in;
         set_mode_ff  <= set_mode_in;
         scan_pos_ff  <= scan_pos_in;
      end
   end

endmodule

FILE: design/hhmm_clock_with_segment_scan.sv
// top level of the hours-and-minutes clock with four-digit segment scan
`timescale 1ns / 1ps

// usage
//  req_*: one event item per handshake (second tick, serial byte, button
//    sample, half-second tick, scan step); accepted when req_valid is high
//    and req_stall is low
//  rsp_*: exactly one result item per event, in order, taken when
//    rsp_valid is high and rsp_stall is low
//  csr_*: writes hour_limit (index 0) and minute_limit (index 1); always
//    ready, write only while no item is in flight
//  flow: an accepted item's state update and result are formed while it
//    sits in the input register and land in the result register once
//    that register is free, which raises rsp_valid
//  throughput: one item per cycle while rsp_stall is low, set by the
//    combinational clock state update between the input and result registers
//  reset: time, received values, blink, set mode and scan position clear,
//    limits go to 23 and 59, both registers empty
//  receiver stall: the result register holds, the input register keeps its
//    item, and req_stall rises only once both are full
module hhmm_clock_with_segment_scan (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  hhmm_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output hhmm_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hhmm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [hhmm_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   // input register
   logic              in_valid_ff, in_valid_in;
   hhmm_pkg::req_type in_data_ff;
   // result register
   logic              out_valid_ff, out_valid_in;
   hhmm_pkg::rsp_type out_data_ff;
   // limits
   hhmm_pkg::limits_type limits_ff, limits_in;

   logic              advance;
   logic              fire;
   logic              take;
   hhmm_pkg::rsp_type result;

   // result register frees up when empty or being taken
   assign advance   = !out_valid_ff || !rsp_stall;
   // item in the input register moves into the result register
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
      end
      limits_in = limits_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            hhmm_pkg::CSR_HOUR_LIMIT:   limits_in.hour_limit   = csr_data[4:0];
            hhmm_pkg::CSR_MINUTE_LIMIT: limits_in.minute_limit = csr_data[5:0];
            default: begin
            end
         endcase
      end
   end

   hhmm_clock_core u_clock_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_data_ff),
      .limits (limits_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
         limits_ff.hour_limit   <= hhmm_pkg::HOUR_LIMIT_RESET;
         limits_ff.minute_limit <= hhmm_pkg::MINUTE_LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         limits_ff    <= limits_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= result;
      end
   end

endmodule
